// File: rtl/v3alu_pkg.sv
// shared types, constants and helpers of the 3d vector unit
`default_nettype none

package v3alu_pkg;

    localparam int DEF_FRAC_BITS = 16;
    localparam int SQRT_STEPS    = 32;

    typedef enum logic [3:0] {
        OP_ADD     = 4'd0,
        OP_SUB     = 4'd1,
        OP_DOT     = 4'd2,
        OP_CROSS   = 4'd3,
        OP_SCALE   = 4'd4,
        OP_MAG     = 4'd5,
        OP_MAGSQ   = 4'd6,
        OP_DIST    = 4'd7,
        OP_DISTSQ  = 4'd8,
        OP_NORM    = 4'd9,
        OP_TRINORM = 4'd10
    } v3alu_op_t;

    localparam logic [31:0] SAT_MAX = 32'h7fff_ffff;
    localparam logic [31:0] SAT_MIN = 32'h8000_0000;

    // everything that rides along with a word through the root and divide pipes
    typedef struct packed {
        logic [3:0]       op;
        logic [2:0][31:0] vec;
        logic [31:0]      sc;
        logic             sat;
        logic             big;
        logic             zl;
    } v3alu_tag_t;

    typedef struct packed {
        logic        ovf;
        logic [31:0] val;
    } sat_t;

    typedef struct packed {
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        logic [31:0] sc;
        logic        zl;
        logic        sat;
    } res_t;

    function automatic sat_t sat32(input logic signed [69:0] v);
        sat_t r;
        if (v > 70'sd2147483647) begin
            r.ovf = 1'b1;
            r.val = SAT_MAX;
        end else if (v < -70'sd2147483648) begin
            r.ovf = 1'b1;
            r.val = SAT_MIN;
        end else begin
            r.ovf = 1'b0;
            r.val = v[31:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// File: rtl/v3alu_sqrt.sv
// pipelined integer square root of a 64-bit value, one root bit per stage
`default_nettype none

module v3alu_sqrt
    import v3alu_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        en,
    input  logic        in_valid,
    input  logic [63:0] in_x,
    input  v3alu_tag_t  in_tag,
    output logic        out_valid,
    output logic [31:0] out_root,
    output v3alu_tag_t  out_tag
);

    logic        vld_reg [SQRT_STEPS+1];
    logic [63:0] x_reg   [SQRT_STEPS];
    logic [63:0] r_reg   [SQRT_STEPS+1];
    v3alu_tag_t  tag_reg [SQRT_STEPS+1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg[0] <= 1'b0;
        end else if (en) begin
            vld_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg[0]   <= in_x;
            r_reg[0]   <= '0;
            tag_reg[0] <= in_tag;
        end
    end

    for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_step
        logic [63:0] bit_w;
        logic [63:0] trial;
        logic [63:0] x_next;
        logic [63:0] r_next;

        always_comb begin
            bit_w = 64'd1 << (62 - 2 * j);
            trial = r_reg[j] + bit_w;
            if (x_reg[j] >= trial) begin
                x_next = x_reg[j] - trial;
                r_next = (r_reg[j] >> 1) + bit_w;
            end else begin
                x_next = x_reg[j];
                r_next = r_reg[j] >> 1;
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[j+1] <= 1'b0;
            end else if (en) begin
                vld_reg[j+1] <= vld_reg[j];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                r_reg[j+1]   <= r_next;
                tag_reg[j+1] <= tag_reg[j];
            end
        end

        if (j < SQRT_STEPS - 1) begin : g_fwd
            always_ff @(posedge aclk) begin
                if (en) begin
                    x_reg[j+1] <= x_next;
                end
            end
        end else begin : g_last
            // remainder of the last step is not needed
        end
    end

    assign out_valid = vld_reg[SQRT_STEPS];
    assign out_root  = r_reg[SQRT_STEPS][31:0];
    assign out_tag   = tag_reg[SQRT_STEPS];

endmodule

`default_nettype wire

// File: rtl/v3alu_div.sv
// three-lane pipelined restoring divider, one quotient bit per stage
`default_nettype none

module v3alu_div
    import v3alu_pkg::*;
#(
    parameter int FRAC_BITS = DEF_FRAC_BITS
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      en,
    input  logic                      in_valid,
    input  logic [2:0][31:0]          in_num,
    input  logic [31:0]               in_den,
    input  v3alu_tag_t                in_tag,
    output logic                      out_valid,
    output logic [2:0][FRAC_BITS:0]   out_quo,
    output v3alu_tag_t                out_tag
);

    localparam int STEPS = FRAC_BITS + 1;
    localparam int RW    = 32 + FRAC_BITS;

    logic                    vld_reg [STEPS+1];
    logic [2:0][RW-1:0]      rem_reg [STEPS];
    logic [31:0]             den_reg [STEPS];
    logic [2:0][FRAC_BITS:0] quo_reg [STEPS+1];
    v3alu_tag_t              tag_reg [STEPS+1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg[0] <= 1'b0;
        end else if (en) begin
            vld_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                rem_reg[0][i] <= {in_num[i], {FRAC_BITS{1'b0}}};
            end
            den_reg[0] <= in_den;
            quo_reg[0] <= '0;
            tag_reg[0] <= in_tag;
        end
    end

    for (genvar j = 0; j < STEPS; j++) begin : g_step
        localparam int K = FRAC_BITS - j;
        logic [RW-1:0]           trial;
        logic [2:0][RW-1:0]      rem_next;
        logic [2:0][FRAC_BITS:0] quo_next;

        always_comb begin
            trial = RW'(den_reg[j]) << K;
            for (int i = 0; i < 3; i++) begin
                rem_next[i] = rem_reg[j][i];
                quo_next[i] = quo_reg[j][i];
                if (rem_reg[j][i] >= trial) begin
                    rem_next[i]    = rem_reg[j][i] - trial;
                    quo_next[i][K] = 1'b1;
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[j+1] <= 1'b0;
            end else if (en) begin
                vld_reg[j+1] <= vld_reg[j];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                quo_reg[j+1] <= quo_next;
                tag_reg[j+1] <= tag_reg[j];
            end
        end

        if (j < STEPS - 1) begin : g_fwd
            always_ff @(posedge aclk) begin
                if (en) begin
                    rem_reg[j+1] <= rem_next;
                    den_reg[j+1] <= den_reg[j];
                end
            end
        end else begin : g_last
            // final remainder is dropped
        end
    end

    assign out_valid = vld_reg[STEPS];
    assign out_quo   = quo_reg[STEPS];
    assign out_tag   = tag_reg[STEPS];

endmodule

`default_nettype wire

// File: rtl/vector3_alu.sv
// top level of the pipelined 3d vector unit
`default_nettype none

// Fixed-point 3d vector unit (signed, FRAC_BITS fraction bits, Q16.16 by default) that
// takes one word per cycle while s_ready is high and returns one result word per word,
// in order. It has five front stages (input register, operand select, 33x33 multiply,
// sum and clamp, squaring for normalize), a 33-stage square root pipe, a FRAC_BITS+2
// stage divide pipe and the output register. The whole pipe advances together; a
// two-entry output buffer keeps the input open while one finished result waits to be
// taken.

module vector3_alu
    import v3alu_pkg::*;
#(
    parameter int FRAC_BITS = DEF_FRAC_BITS
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [3:0]         s_opcode,
    input  logic signed [31:0] s_a_x,
    input  logic signed [31:0] s_a_y,
    input  logic signed [31:0] s_a_z,
    input  logic signed [31:0] s_b_x,
    input  logic signed [31:0] s_b_y,
    input  logic signed [31:0] s_b_z,
    input  logic signed [31:0] s_c_x,
    input  logic signed [31:0] s_c_y,
    input  logic signed [31:0] s_c_z,
    input  logic signed [31:0] s_factor,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_res_x,
    output logic signed [31:0] m_res_y,
    output logic signed [31:0] m_res_z,
    output logic signed [31:0] m_res_scalar,
    output logic               m_zero_length,
    output logic               m_saturated
);

    logic en;
    logic head_valid_reg;
    logic skid_valid_reg;
    res_t head_reg;
    res_t skid_reg;

    assign en      = !skid_valid_reg;
    assign s_ready = en;

    // stage 1: input register
    logic               v1_reg;
    logic [3:0]         op1_reg;
    logic signed [31:0] a1_reg [3];
    logic signed [31:0] b1_reg [3];
    logic signed [31:0] c1_reg [3];
    logic signed [31:0] f1_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            op1_reg   <= s_opcode;
            a1_reg[0] <= s_a_x;
            a1_reg[1] <= s_a_y;
            a1_reg[2] <= s_a_z;
            b1_reg[0] <= s_b_x;
            b1_reg[1] <= s_b_y;
            b1_reg[2] <= s_b_z;
            c1_reg[0] <= s_c_x;
            c1_reg[1] <= s_c_y;
            c1_reg[2] <= s_c_z;
            f1_reg    <= s_factor;
        end
    end

    // stage 1 -> 2: sums, differences and multiplier operand select
    logic signed [32:0] mx_next [6];
    logic signed [32:0] my_next [6];
    logic [2:0][31:0]   vec2_next;
    logic               sat2_next;

    always_comb begin
        sat_t               add_s [3];
        sat_t               sub_s [3];
        sat_t               ba_s  [3];
        sat_t               ca_s  [3];
        logic signed [32:0] dd    [3];
        logic signed [32:0] u     [3];
        logic signed [32:0] v     [3];

        for (int i = 0; i < 3; i++) begin
            add_s[i] = sat32(70'(a1_reg[i]) + 70'(b1_reg[i]));
            sub_s[i] = sat32(70'(a1_reg[i]) - 70'(b1_reg[i]));
            ba_s[i]  = sat32(70'(b1_reg[i]) - 70'(a1_reg[i]));
            ca_s[i]  = sat32(70'(c1_reg[i]) - 70'(a1_reg[i]));
            dd[i]    = 33'(a1_reg[i]) - 33'(b1_reg[i]);
            if (op1_reg == OP_TRINORM) begin
                u[i] = 33'($signed(ba_s[i].val));
                v[i] = 33'($signed(ca_s[i].val));
            end else begin
                u[i] = 33'(a1_reg[i]);
                v[i] = 33'(b1_reg[i]);
            end
        end

        for (int k = 0; k < 6; k++) begin
            mx_next[k] = '0;
            my_next[k] = '0;
        end
        vec2_next = '0;
        sat2_next = 1'b0;

        case (op1_reg)
            OP_ADD: begin
                for (int i = 0; i < 3; i++) begin
                    vec2_next[i] = add_s[i].val;
                    sat2_next    = sat2_next | add_s[i].ovf;
                end
            end
            OP_SUB: begin
                for (int i = 0; i < 3; i++) begin
                    vec2_next[i] = sub_s[i].val;
                    sat2_next    = sat2_next | sub_s[i].ovf;
                end
            end
            OP_DOT: begin
                for (int i = 0; i < 3; i++) begin
                    mx_next[i] = 33'(a1_reg[i]);
                    my_next[i] = 33'(b1_reg[i]);
                end
            end
            OP_CROSS, OP_TRINORM: begin
                mx_next[0] = u[1]; my_next[0] = v[2];
                mx_next[1] = u[2]; my_next[1] = v[1];
                mx_next[2] = u[2]; my_next[2] = v[0];
                mx_next[3] = u[0]; my_next[3] = v[2];
                mx_next[4] = u[0]; my_next[4] = v[1];
                mx_next[5] = u[1]; my_next[5] = v[0];
                if (op1_reg == OP_TRINORM) begin
                    for (int i = 0; i < 3; i++) begin
                        sat2_next = sat2_next | ba_s[i].ovf | ca_s[i].ovf;
                    end
                end
            end
            OP_SCALE: begin
                for (int i = 0; i < 3; i++) begin
                    mx_next[i] = 33'(a1_reg[i]);
                    my_next[i] = 33'(f1_reg);
                end
            end
            OP_MAG, OP_MAGSQ: begin
                for (int i = 0; i < 3; i++) begin
                    mx_next[i] = 33'(a1_reg[i]);
                    my_next[i] = 33'(a1_reg[i]);
                end
            end
            OP_DIST, OP_DISTSQ: begin
                for (int i = 0; i < 3; i++) begin
                    mx_next[i] = dd[i];
                    my_next[i] = dd[i];
                end
            end
            OP_NORM: begin
                for (int i = 0; i < 3; i++) begin
                    vec2_next[i] = a1_reg[i];
                end
            end
            default: begin
            end
        endcase
    end

    // stage 2: operands
    logic               v2_reg;
    logic [3:0]         op2_reg;
    logic signed [32:0] mx2_reg [6];
    logic signed [32:0] my2_reg [6];
    logic [2:0][31:0]   vec2_reg;
    logic               sat2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (en) begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            op2_reg  <= op1_reg;
            mx2_reg  <= mx_next;
            my2_reg  <= my_next;
            vec2_reg <= vec2_next;
            sat2_reg <= sat2_next;
        end
    end

    // stage 3: products
    logic               v3_reg;
    logic [3:0]         op3_reg;
    logic signed [65:0] p3_reg [6];
    logic [2:0][31:0]   vec3_reg;
    logic               sat3_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (en) begin
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            op3_reg <= op2_reg;
            for (int k = 0; k < 6; k++) begin
                p3_reg[k] <= mx2_reg[k] * my2_reg[k];
            end
            vec3_reg <= vec2_reg;
            sat3_reg <= sat2_reg;
        end
    end

    // stage 3 -> 4: exact sums, floor shift, clamp
    v3alu_tag_t  tag4_next;
    logic [63:0] s64_4_next;

    always_comb begin
        logic signed [69:0] sum3;
        logic [66:0]        ssq;
        sat_t               ds;
        sat_t               cs [3];
        sat_t               ss [3];

        sum3  = 70'(p3_reg[0]) + 70'(p3_reg[1]) + 70'(p3_reg[2]);
        ssq   = sum3[66:0];
        ds    = sat32(sum3 >>> FRAC_BITS);
        cs[0] = sat32((70'(p3_reg[0]) - 70'(p3_reg[1])) >>> FRAC_BITS);
        cs[1] = sat32((70'(p3_reg[2]) - 70'(p3_reg[3])) >>> FRAC_BITS);
        cs[2] = sat32((70'(p3_reg[4]) - 70'(p3_reg[5])) >>> FRAC_BITS);
        for (int i = 0; i < 3; i++) begin
            ss[i] = sat32(70'(p3_reg[i]) >>> FRAC_BITS);
        end

        tag4_next.op  = op3_reg;
        tag4_next.vec = vec3_reg;
        tag4_next.sc  = '0;
        tag4_next.sat = sat3_reg;
        tag4_next.big = 1'b0;
        tag4_next.zl  = 1'b0;
        s64_4_next    = ssq[63:0];

        case (op3_reg)
            OP_DOT: begin
                tag4_next.sc  = ds.val;
                tag4_next.sat = ds.ovf;
            end
            OP_CROSS, OP_TRINORM: begin
                for (int i = 0; i < 3; i++) begin
                    tag4_next.vec[i] = cs[i].val;
                    tag4_next.sat    = tag4_next.sat | cs[i].ovf;
                end
            end
            OP_SCALE: begin
                for (int i = 0; i < 3; i++) begin
                    tag4_next.vec[i] = ss[i].val;
                    tag4_next.sat    = tag4_next.sat | ss[i].ovf;
                end
            end
            OP_MAGSQ, OP_DISTSQ: begin
                if (ssq[66:FRAC_BITS+31] != '0) begin
                    tag4_next.sc  = SAT_MAX;
                    tag4_next.sat = 1'b1;
                end else begin
                    tag4_next.sc = 32'(ssq >> FRAC_BITS);
                end
            end
            OP_MAG, OP_DIST: begin
                tag4_next.big = |ssq[66:64];
            end
            default: begin
            end
        endcase
    end

    // stage 4
    logic        v4_reg;
    v3alu_tag_t  tag4_reg;
    logic [63:0] s64_4_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v4_reg <= 1'b0;
        end else if (en) begin
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            tag4_reg  <= tag4_next;
            s64_4_reg <= s64_4_next;
        end
    end

    // stage 5: squares of the vector to normalize
    logic        v5_reg;
    v3alu_tag_t  tag5_reg;
    logic [63:0] s64_5_reg;
    logic [63:0] sq5_reg [3];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v5_reg <= 1'b0;
        end else if (en) begin
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            tag5_reg  <= tag4_reg;
            s64_5_reg <= s64_4_reg;
            for (int i = 0; i < 3; i++) begin
                sq5_reg[i] <= $signed(tag4_reg.vec[i]) * $signed(tag4_reg.vec[i]);
            end
        end
    end

    logic        is_norm5;
    logic [63:0] root_x;

    // three 32-bit squares cannot carry out of 64 bits
    assign is_norm5 = (tag5_reg.op == OP_NORM) || (tag5_reg.op == OP_TRINORM);
    assign root_x   = is_norm5 ? (sq5_reg[0] + sq5_reg[1] + sq5_reg[2]) : s64_5_reg;

    logic        sq_valid;
    logic [31:0] sq_root;
    v3alu_tag_t  sq_tag;

    v3alu_sqrt u_sqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (v5_reg),
        .in_x      (root_x),
        .in_tag    (tag5_reg),
        .out_valid (sq_valid),
        .out_root  (sq_root),
        .out_tag   (sq_tag)
    );

    // root lands in the scalar for magnitude ops; zero root flags a degenerate normalize
    v3alu_tag_t       div_tag_in;
    logic [2:0][31:0] div_num;

    always_comb begin
        div_tag_in = sq_tag;
        for (int i = 0; i < 3; i++) begin
            div_num[i] = sq_tag.vec[i][31] ? (32'd0 - sq_tag.vec[i]) : sq_tag.vec[i];
        end
        if ((sq_tag.op == OP_MAG) || (sq_tag.op == OP_DIST)) begin
            if (sq_tag.big || sq_root[31]) begin
                div_tag_in.sc  = SAT_MAX;
                div_tag_in.sat = 1'b1;
            end else begin
                div_tag_in.sc = sq_root;
            end
        end
        if (((sq_tag.op == OP_NORM) || (sq_tag.op == OP_TRINORM)) && (sq_root == '0)) begin
            div_tag_in.zl = 1'b1;
        end
    end

    logic                    dv_valid;
    logic [2:0][FRAC_BITS:0] dv_quo;
    v3alu_tag_t              dv_tag;

    v3alu_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (sq_valid),
        .in_num    (div_num),
        .in_den    (sq_root),
        .in_tag    (div_tag_in),
        .out_valid (dv_valid),
        .out_quo   (dv_quo),
        .out_tag   (dv_tag)
    );

    // final word
    res_t             fin;
    logic [2:0][31:0] fin_vec;

    always_comb begin
        fin_vec = dv_tag.vec;
        if ((dv_tag.op == OP_NORM) || (dv_tag.op == OP_TRINORM)) begin
            for (int i = 0; i < 3; i++) begin
                if (dv_tag.zl) begin
                    fin_vec[i] = '0;
                end else if (dv_tag.vec[i][31]) begin
                    fin_vec[i] = 32'd0 - 32'(dv_quo[i]);
                end else begin
                    fin_vec[i] = 32'(dv_quo[i]);
                end
            end
        end
        fin.x   = fin_vec[0];
        fin.y   = fin_vec[1];
        fin.z   = fin_vec[2];
        fin.sc  = dv_tag.sc;
        fin.zl  = dv_tag.zl;
        fin.sat = dv_tag.sat;
    end

    // two-entry output buffer
    logic push;
    logic pop;

    assign push = en && dv_valid;
    assign pop  = head_valid_reg && m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (pop) begin
                if (skid_valid_reg) begin
                    head_valid_reg <= 1'b1;
                    skid_valid_reg <= 1'b0;
                end else begin
                    head_valid_reg <= push;
                end
            end else if (!head_valid_reg) begin
                head_valid_reg <= push;
            end else if (push) begin
                skid_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop && skid_valid_reg) begin
            head_reg <= skid_reg;
        end else if (push && (pop || !head_valid_reg)) begin
            head_reg <= fin;
        end
        if (push && head_valid_reg && !pop) begin
            skid_reg <= fin;
        end
    end

    assign m_valid       = head_valid_reg;
    assign m_res_x       = head_reg.x;
    assign m_res_y       = head_reg.y;
    assign m_res_z       = head_reg.z;
    assign m_res_scalar  = head_reg.sc;
    assign m_zero_length = head_reg.zl;
    assign m_saturated   = head_reg.sat;

    a_skid_needs_head: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> head_valid_reg)
        else $error("skid word held with empty head");

    a_skid_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg && !pop |=> skid_valid_reg)
        else $error("skid word lost without a drain");

    a_zero_len_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        head_valid_reg && head_reg.zl |->
            (head_reg.x == '0) && (head_reg.y == '0) && (head_reg.z == '0) &&
            (head_reg.sc == '0))
        else $error("zero length word carries nonzero data");

    a_scalar_or_vector: assert property (@(posedge aclk) disable iff (!aresetn)
        head_valid_reg && (head_reg.sc != '0) |->
            (head_reg.x == '0) && (head_reg.y == '0) && (head_reg.z == '0))
        else $error("scalar and vector result both nonzero");

endmodule

`default_nettype wire

// File: sim/testbench.sv
// self-checking testbench for the pipelined 3d vector unit
`default_nettype none

module testbench;
    import v3alu_pkg::*;

    typedef logic signed [127:0] wide_t;

    typedef struct packed {
        logic [3:0]       op;
        logic [2:0][31:0] a;
        logic [2:0][31:0] b;
        logic [2:0][31:0] c;
        logic [31:0]      f;
    } vec_word_t;

    localparam int    FRAC      = DEF_FRAC_BITS;
    localparam int    N_RANDOM  = 630;
    localparam int    IDLE_MAX  = 5000;
    localparam wide_t Q_MAX     = 128'sd2147483647;
    localparam wide_t Q_MIN     = -128'sd2147483648;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [3:0] s_opcode = '0;
    logic signed [31:0] s_a_x = '0, s_a_y = '0, s_a_z = '0;
    logic signed [31:0] s_b_x = '0, s_b_y = '0, s_b_z = '0;
    logic signed [31:0] s_c_x = '0, s_c_y = '0, s_c_z = '0;
    logic signed [31:0] s_factor = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic signed [31:0] m_res_x, m_res_y, m_res_z, m_res_scalar;
    logic m_zero_length, m_saturated;

    vector3_alu i_dut (.*);

    always #5 aclk = ~aclk;

    vec_word_t pending_words[$];
    res_t      expected_results[$];
    vec_word_t drive_word;
    int        src_gap = 0;
    int        sink_gap = 0;
    int        hold_left = 0;
    bit        hold_done = 1'b0;
    int        words_in = 0;
    int        mismatches = 0;
    int        idle_cycles = 0;

    // ---------------- exact fixed-point arithmetic ----------------

    function automatic wide_t clamp32(input wide_t v, inout logic sat);
        if (v > Q_MAX) begin
            sat = 1'b1;
            return Q_MAX;
        end
        if (v < Q_MIN) begin
            sat = 1'b1;
            return Q_MIN;
        end
        return v;
    endfunction

    function automatic wide_t sqrt_floor(input wide_t x);
        logic [127:0] r, t;
        r = '0;
        for (int i = 40; i >= 0; i--) begin
            t = r | (128'd1 << i);
            if (t * t <= x) r = t;
        end
        return wide_t'(r);
    endfunction

    function automatic void cross_q(input wide_t u[3], input wide_t v[3],
                                    output wide_t r[3], inout logic sat);
        r[0] = clamp32((u[1] * v[2] - u[2] * v[1]) >>> FRAC, sat);
        r[1] = clamp32((u[2] * v[0] - u[0] * v[2]) >>> FRAC, sat);
        r[2] = clamp32((u[0] * v[1] - u[1] * v[0]) >>> FRAC, sat);
    endfunction

    function automatic void unit_q(input wide_t v[3], output wide_t r[3], inout logic zl);
        wide_t m;
        m = sqrt_floor(v[0] * v[0] + v[1] * v[1] + v[2] * v[2]);
        for (int i = 0; i < 3; i++) r[i] = 0;
        if (m == 0) zl = 1'b1;
        else for (int i = 0; i < 3; i++) r[i] = (v[i] <<< FRAC) / m;
    endfunction

    function automatic res_t predict_result(input vec_word_t w);
        wide_t a[3], b[3], c[3], d[3], e[3], t[3], r[3];
        wide_t f, sc, s, q;
        logic sat, zl;
        res_t res;
        sat = 1'b0;
        zl = 1'b0;
        sc = 0;
        f = wide_t'($signed(w.f));
        for (int i = 0; i < 3; i++) begin
            a[i] = wide_t'($signed(w.a[i]));
            b[i] = wide_t'($signed(w.b[i]));
            c[i] = wide_t'($signed(w.c[i]));
            r[i] = 0;
        end
        case (v3alu_op_t'(w.op))
            OP_ADD:   for (int i = 0; i < 3; i++) r[i] = clamp32(a[i] + b[i], sat);
            OP_SUB:   for (int i = 0; i < 3; i++) r[i] = clamp32(a[i] - b[i], sat);
            OP_DOT:   sc = clamp32((a[0] * b[0] + a[1] * b[1] + a[2] * b[2]) >>> FRAC, sat);
            OP_CROSS: cross_q(a, b, r, sat);
            OP_SCALE: for (int i = 0; i < 3; i++) r[i] = clamp32((a[i] * f) >>> FRAC, sat);
            OP_MAG, OP_MAGSQ, OP_DIST, OP_DISTSQ: begin
                for (int i = 0; i < 3; i++)
                    d[i] = (w.op == OP_DIST || w.op == OP_DISTSQ) ? a[i] - b[i] : a[i];
                s = d[0] * d[0] + d[1] * d[1] + d[2] * d[2];
                q = (w.op == OP_MAG || w.op == OP_DIST) ? sqrt_floor(s) : s >>> FRAC;
                sc = clamp32(q, sat);
            end
            OP_NORM:  unit_q(a, r, zl);
            OP_TRINORM: begin
                for (int i = 0; i < 3; i++) begin
                    d[i] = clamp32(b[i] - a[i], sat);
                    e[i] = clamp32(c[i] - a[i], sat);
                end
                cross_q(d, e, t, sat);
                unit_q(t, r, zl);
            end
            default: ;
        endcase
        res.x   = r[0][31:0];
        res.y   = r[1][31:0];
        res.z   = r[2][31:0];
        res.sc  = sc[31:0];
        res.zl  = zl;
        res.sat = sat;
        return res;
    endfunction

    // ---------------- stimulus ----------------

    function automatic logic [2:0][31:0] v3(input int x, input int y, input int z);
        return {z, y, x};
    endfunction

    function automatic logic [31:0] rand_comp();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return $urandom;
            4, 5, 6:    return int'($urandom_range(0, 1 << 21)) - (1 << 20);
            7: case ($urandom_range(0, 4))
                   0: return 32'h7fff_ffff;
                   1: return 32'h8000_0000;
                   2: return 32'h0;
                   3: return 32'hffff_ffff;
                   default: return 32'h1;
               endcase
            8: return (int'($urandom_range(0, 64)) - 32) <<< FRAC;
            default: return int'($urandom_range(0, 1 << 27)) - (1 << 26);
        endcase
    endfunction

    function automatic vec_word_t rand_word();
        vec_word_t w;
        for (int i = 0; i < 3; i++) begin
            w.a[i] = rand_comp();
            w.b[i] = rand_comp();
            w.c[i] = rand_comp();
        end
        w.f = rand_comp();
        w.op = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(11, 15))
                                           : 4'($urandom_range(0, 10));
        // zero vectors and degenerate triangles
        case ($urandom_range(0, 11))
            0: w.a = '0;
            1: w.c = w.b;
            2: w.b = w.a;
            3: w.c = w.a;
            default: ;
        endcase
        return w;
    endfunction

    function automatic vec_word_t mk(input logic [3:0] op, input logic [2:0][31:0] a,
                                     input logic [2:0][31:0] b, input logic [2:0][31:0] c,
                                     input int f);
        vec_word_t w;
        w.op = op; w.a = a; w.b = b; w.c = c; w.f = f;
        return w;
    endfunction

    initial begin
        logic [2:0][31:0] vmax, vmin, one, zero;
        vmax = v3(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
        vmin = v3(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        one  = v3(1 << FRAC, 2 << FRAC, -(3 << FRAC));
        zero = '0;
        pending_words.push_back(mk(OP_ADD, vmax, vmax, zero, 0));
        pending_words.push_back(mk(OP_ADD, vmin, vmin, zero, 0));
        pending_words.push_back(mk(OP_ADD, one, one, zero, 0));
        pending_words.push_back(mk(OP_SUB, vmin, vmax, zero, 0));
        pending_words.push_back(mk(OP_DOT, vmax, vmin, zero, 0));
        pending_words.push_back(mk(OP_DOT, one, one, zero, 0));
        pending_words.push_back(mk(OP_CROSS, vmax, v3(32'h8000_0000, 5, 32'h7fff_ffff),
                                   zero, 0));
        pending_words.push_back(mk(OP_SCALE, vmax, zero, zero, 32'h8000_0000));
        pending_words.push_back(mk(OP_SCALE, v3(-1, 1, 3), zero, zero, -1));
        pending_words.push_back(mk(OP_MAG, vmin, zero, zero, 0));
        pending_words.push_back(mk(OP_MAG, one, zero, zero, 0));
        pending_words.push_back(mk(OP_MAGSQ, vmax, zero, zero, 0));
        pending_words.push_back(mk(OP_DIST, vmax, vmin, zero, 0));
        pending_words.push_back(mk(OP_DISTSQ, one, zero, zero, 0));
        pending_words.push_back(mk(OP_NORM, zero, one, one, 0));
        pending_words.push_back(mk(OP_NORM, v3(1, 0, 0), zero, zero, 0));
        pending_words.push_back(mk(OP_NORM, vmin, zero, zero, 0));
        pending_words.push_back(mk(OP_TRINORM, one, one, vmax, 0));
        pending_words.push_back(mk(OP_TRINORM, vmin, vmax, v3(32'h7fff_ffff, 0, 32'h8000_0000),
                                   0));
        pending_words.push_back(mk(OP_TRINORM, zero, v3(1 << FRAC, 0, 0), v3(0, 1 << FRAC, 0),
                                   0));
        pending_words.push_back(mk(4'd11, vmax, vmax, vmax, -1));
        pending_words.push_back(mk(4'd15, vmin, vmin, vmin, -1));
        for (int i = 0; i < N_RANDOM; i++) pending_words.push_back(rand_word());

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        while (pending_words.size() > 0 || s_valid || expected_results.size() > 0)
            @(posedge aclk);
        repeat (100) @(posedge aclk);
        if (mismatches == 0)
            $display("[vector3_alu] OK");
        else
            $display("[vector3_alu] ERROR");
        $finish;
    end

    // ---------------- driver ----------------

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (src_gap > 0) begin
                src_gap--;
                s_valid <= 1'b0;
            end else if (pending_words.size() > 0) begin
                drive_word = pending_words.pop_front();
                s_opcode <= drive_word.op;
                s_a_x <= drive_word.a[0]; s_a_y <= drive_word.a[1]; s_a_z <= drive_word.a[2];
                s_b_x <= drive_word.b[0]; s_b_y <= drive_word.b[1]; s_b_z <= drive_word.b[2];
                s_c_x <= drive_word.c[0]; s_c_y <= drive_word.c[1]; s_c_z <= drive_word.c[2];
                s_factor <= drive_word.f;
                s_valid <= 1'b1;
                // no idling near the end of the run
                if (pending_words.size() > 80 && $urandom_range(0, 9) == 0)
                    src_gap = $urandom_range(1, 12);
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // ---------------- receiver ----------------

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else if (!hold_done && words_in >= 300) begin
            // long hold-off so the pipe fills and stalls the input
            hold_done = 1'b1;
            hold_left = 400;
            m_ready <= 1'b0;
        end else if (sink_gap > 0) begin
            sink_gap--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
            if (pending_words.size() > 80 && $urandom_range(0, 9) == 0)
                sink_gap = $urandom_range(1, 12);
        end
    end

    // ---------------- monitor and checker ----------------

    always @(posedge aclk) begin
        vec_word_t w;
        res_t got, want;
        if (aresetn && s_valid && s_ready) begin
            w.op = s_opcode;
            w.a = {s_a_z, s_a_y, s_a_x};
            w.b = {s_b_z, s_b_y, s_b_x};
            w.c = {s_c_z, s_c_y, s_c_x};
            w.f = s_factor;
            expected_results.push_back(predict_result(w));
            words_in++;
        end
        if (aresetn && m_valid && m_ready) begin
            got = '{m_res_x, m_res_y, m_res_z, m_res_scalar, m_zero_length, m_saturated};
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result word %p", got);
            end else begin
                want = expected_results.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected x=%h y=%h z=%h sc=%h zl=%b sat=%b, ",
                                 want.x, want.y, want.z, want.sc, want.zl, want.sat,
                                 "got x=%h y=%h z=%h sc=%h zl=%b sat=%b",
                                 got.x, got.y, got.z, got.sc, got.zl, got.sat);
                end
            end
        end
    end

    // ---------------- watchdog ----------------

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn) idle_cycles = 0;
        else idle_cycles++;
        if (idle_cycles >= IDLE_MAX) begin
            $display("[vector3_alu] ERROR");
            $finish;
        end
    end

endmodule

`default_nettype wire

// File: vector3_alu.f
rtl/v3alu_pkg.sv
rtl/v3alu_sqrt.sv
rtl/v3alu_div.sv
rtl/vector3_alu.sv
sim/testbench.sv
